/* rtl/rie_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_pkg: shared types and constants for the postfix evaluator
// Character codes, status codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rie_pkg;

   localparam int DATA_W   = 32;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;

   // character codes
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_DIVZ  = 3'd3,
      ST_LEFT  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FINISH,
      S_DISPATCH,
      S_RD_T,
      S_RD_S,
      S_EXEC,
      S_DIV_WAIT,
      S_PUSH,
      S_BANG_RD,
      S_NL_RD,
      S_NL_OUT
   } state_type;

   typedef enum logic {
      RD_TOP,
      RD_SECOND
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       latch_char;
      logic       digit_step;
      logic       push_accum;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cap_t;
      logic       cap_s;
      logic       exec_arith;
      logic       div_zero;
      logic       div_start;
      logic       div_take;
      logic       push_result;
      logic       bang_write;
      logic       nl_take;
      logic       nl_zero;
      logic       flag_under;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_digit;
      logic is_binary;
      logic is_divmod;
      logic is_bang;
      logic is_newline;
      logic count_lt2;
      logic count_zero;
      logic b_zero;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_binary_op(input logic [CHAR_W-1:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_PERCENT};
   endfunction

   function automatic logic is_divmod_op(input logic [CHAR_W-1:0] c);
      return c inside {CH_SLASH, CH_PERCENT};
   endfunction

endpackage
`default_nettype wire

/* rtl/rpn_integer_evaluator.sv */
// A digit is folded into the number as it is taken; other characters walk
// the controller states, and / and % also wait on the 32-step iterative divider.
// Throughput: one character at a time; the next is taken once the current
// one has finished its stack reads, ALU step and push.
// A newline result sits in an output register; a later newline waits for it.
// Reset (synchronous, active high) empties the stack and clears the line.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_integer_evaluator: postfix integer expression evaluator
// Consumes one character per item and returns the value and status of
// each line when its newline arrives.
// ----------------------------------------------------------------------------
module rpn_integer_evaluator #(
   parameter int STACK_DEPTH = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [rie_pkg::CHAR_W-1:0]          req_char_code,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [rie_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [rie_pkg::STATUS_W-1:0]        rsp_status
);

   rie_pkg::cmd_type          cmd;
   rie_pkg::stat_type         stat;
   logic [rie_pkg::DATA_W-1:0] rsp_value;

   rie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rie_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

   assign rsp_result_value = $signed(rsp_value);

endmodule
`default_nettype wire

/* rtl/rie_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/rie_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle. Quotient
// truncates toward zero; remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module rie_divider (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [rie_pkg::DATA_W-1:0]  dividend,
   input  wire  [rie_pkg::DATA_W-1:0]  divisor,
   output logic                        done,
   output logic [rie_pkg::DATA_W-1:0]  quotient,
   output logic [rie_pkg::DATA_W-1:0]  remainder
);

   localparam int DW  = rie_pkg::DATA_W;
   localparam int SCW = $clog2(DW + 1);

   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [DW-1:0]  dvs_ff, dvs_in;
   logic [SCW-1:0] step_ff, step_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           neg_q_ff, neg_q_in;
   logic           neg_r_ff, neg_r_in;

   logic [DW:0]    partial;
   logic [DW:0]    diff;

   // one restoring step
   assign partial = {rem_ff, quo_ff[DW-1]};
   assign diff    = partial - {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
         dvs_in   = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
         step_in  = SCW'(DW);
         busy_in  = 1'b1;
         neg_q_in = dividend[DW-1] ^ divisor[DW-1];
         neg_r_in = dividend[DW-1];
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = partial[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff - SCW'(1);
         if (step_ff == SCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // sign fix-up
   assign done      = done_ff;
   assign quotient  = neg_q_ff ? (~quo_ff + DW'(1)) : quo_ff;
   assign remainder = neg_r_ff ? (~rem_ff + DW'(1)) : rem_ff;

endmodule
`default_nettype wire

/* rtl/rie_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_datapath: stack, number builder, ALU and result register
// Holds the value stack in RAM, the stack count, the number accumulator,
// the line status and the registered result item.
// ----------------------------------------------------------------------------
module rie_datapath #(
   parameter int STACK_DEPTH = 256
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  rie_pkg::cmd_type        cmd,
   output rie_pkg::stat_type             stat,
   input  wire  [rie_pkg::CHAR_W-1:0]    req_char_code,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [rie_pkg::DATA_W-1:0]    rsp_value,
   output logic [rie_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int DW = rie_pkg::DATA_W;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [rie_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [DW-1:0]              accum_ff, accum_in;
   logic                       in_num_ff, in_num_in;
   logic [CW-1:0]              count_ff, count_in;
   rie_pkg::status_type        status_ff, status_in;
   logic [DW-1:0]              opa_ff, opa_in;
   logic [DW-1:0]              opb_ff, opb_in;
   logic [DW-1:0]              result_ff, result_in;
   logic                       out_valid_ff, out_valid_in;
   logic [DW-1:0]              out_value_ff, out_value_in;
   rie_pkg::status_type        out_status_ff, out_status_in;

   logic                       full;
   logic [CW-1:0]              count_m1;
   logic [CW-1:0]              count_m2;
   logic                       flag_en;
   rie_pkg::status_type        flag_code;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [DW-1:0]              wr_data;
   logic [AW-1:0]              rd_addr;
   logic [DW-1:0]              rd_data;

   logic                       div_done;
   logic [DW-1:0]              div_quo;
   logic [DW-1:0]              div_rem;

   assign full     = (count_ff >= CW'(STACK_DEPTH));
   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);

   // stack storage
   rie_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = (cmd.rd_sel == rie_pkg::RD_SECOND) ? count_m2[AW-1:0] : count_m1[AW-1:0];

   // shared divider
   rie_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (opa_ff),
      .divisor   (opb_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // stack write port: pushes and the in-place logical not
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = result_ff;
      if (cmd.bang_write) begin
         wr_en   = 1'b1;
         wr_addr = count_m1[AW-1:0];
         wr_data = (rd_data == '0) ? DW'(1) : '0;
      end else if (cmd.push_accum) begin
         wr_en   = in_num_ff && !full;
         wr_data = accum_ff;
      end else if (cmd.push_result) begin
         wr_en   = !full;
      end
   end

   // main state update
   always_comb begin
      char_in       = char_ff;
      accum_in      = accum_ff;
      in_num_in     = in_num_ff;
      count_in      = count_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      result_in     = result_ff;
      flag_en       = 1'b0;
      flag_code     = rie_pkg::ST_OK;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      if (cmd.latch_char) begin
         char_in = req_char_code;
      end
      // accum * 10 + digit
      if (cmd.digit_step) begin
         accum_in  = (accum_ff << 3) + (accum_ff << 1)
                   + DW'(req_char_code - rie_pkg::CH_ZERO);
         in_num_in = 1'b1;
      end
      // push a finished number
      if (cmd.push_accum && in_num_ff) begin
         if (full) begin
            flag_en   = 1'b1;
            flag_code = rie_pkg::ST_OVER;
         end else begin
            count_in = count_ff + CW'(1);
         end
         in_num_in = 1'b0;
         accum_in  = '0;
      end
      if (cmd.cap_t) begin
         opb_in = rd_data;
      end
      if (cmd.cap_s) begin
         opa_in   = rd_data;
         count_in = count_m2;
      end
      // add (also for ^), subtract, multiply
      if (cmd.exec_arith) begin
         case (char_ff)
            rie_pkg::CH_MINUS: result_in = opa_ff - opb_ff;
            rie_pkg::CH_STAR:  result_in = opa_ff * opb_ff;
            default:           result_in = opa_ff + opb_ff;
         endcase
      end
      if (cmd.div_zero) begin
         result_in = '0;
         flag_en   = 1'b1;
         flag_code = rie_pkg::ST_DIVZ;
      end
      if (cmd.div_take) begin
         result_in = (char_ff == rie_pkg::CH_SLASH) ? div_quo : div_rem;
      end
      if (cmd.push_result) begin
         if (full) begin
            flag_en   = 1'b1;
            flag_code = rie_pkg::ST_OVER;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.flag_under) begin
         flag_en   = 1'b1;
         flag_code = rie_pkg::ST_UNDER;
      end
      if (cmd.nl_zero) begin
         result_in = '0;
      end
      // end of line: take the top, note anything left below it
      if (cmd.nl_take) begin
         result_in = rd_data;
         if (count_m1 != '0) begin
            flag_en   = 1'b1;
            flag_code = rie_pkg::ST_LEFT;
         end
      end

      // first error of the line wins
      status_in = status_ff;
      if (flag_en && status_ff == rie_pkg::ST_OK) begin
         status_in = flag_code;
      end

      // deliver the result item and clear the line
      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_value_in  = result_ff;
         out_status_in = status_ff;
         count_in      = '0;
         accum_in      = '0;
         in_num_in     = 1'b0;
         status_in     = rie_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         in_num_ff    <= 1'b0;
         count_ff     <= '0;
         status_ff    <= rie_pkg::ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         in_num_ff    <= in_num_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
      end
      char_ff       <= char_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      result_ff     <= result_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   // status to the controller
   always_comb begin
      stat.in_digit   = rie_pkg::is_digit(req_char_code);
      stat.is_binary  = rie_pkg::is_binary_op(char_ff);
      stat.is_divmod  = rie_pkg::is_divmod_op(char_ff);
      stat.is_bang    = (char_ff == rie_pkg::CH_BANG);
      stat.is_newline = (char_ff == rie_pkg::CH_NEWLINE);
      stat.count_lt2  = (count_ff < CW'(2));
      stat.count_zero = (count_ff == '0);
      stat.b_zero     = (opb_ff == '0);
      stat.div_done   = div_done;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

endmodule
`default_nettype wire

/* rtl/rie_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_ctrl: sequencing state machine
// Takes one character, steps a digit in, or else finishes a pending number
// and walks stack reads, ALU or divider, push or in-place not, and delivery.
// ----------------------------------------------------------------------------
module rie_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  rie_pkg::stat_type   stat,
   output rie_pkg::cmd_type          cmd
);

   rie_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rie_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = rie_pkg::RD_TOP;
      req_ready  = 1'b0;
      case (state_ff)
         rie_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_char = 1'b1;
               if (stat.in_digit) begin
                  cmd.digit_step = 1'b1;
               end else begin
                  state_in = rie_pkg::S_FINISH;
               end
            end
         end
         rie_pkg::S_FINISH: begin
            cmd.push_accum = 1'b1;
            state_in       = rie_pkg::S_DISPATCH;
         end
         rie_pkg::S_DISPATCH: begin
            state_in = rie_pkg::S_IDLE;
            if (stat.is_binary) begin
               if (stat.count_lt2) begin
                  cmd.flag_under = 1'b1;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = rie_pkg::S_RD_T;
               end
            end else if (stat.is_bang) begin
               if (stat.count_zero) begin
                  cmd.flag_under = 1'b1;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = rie_pkg::S_BANG_RD;
               end
            end else if (stat.is_newline) begin
               if (stat.count_zero) begin
                  cmd.flag_under = 1'b1;
                  cmd.nl_zero    = 1'b1;
                  state_in       = rie_pkg::S_NL_OUT;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = rie_pkg::S_NL_RD;
               end
            end
         end
         rie_pkg::S_RD_T: begin
            cmd.cap_t  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = rie_pkg::RD_SECOND;
            state_in   = rie_pkg::S_RD_S;
         end
         rie_pkg::S_RD_S: begin
            cmd.cap_s = 1'b1;
            state_in  = rie_pkg::S_EXEC;
         end
         rie_pkg::S_EXEC: begin
            if (stat.is_divmod) begin
               if (stat.b_zero) begin
                  cmd.div_zero = 1'b1;
                  state_in     = rie_pkg::S_PUSH;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = rie_pkg::S_DIV_WAIT;
               end
            end else begin
               cmd.exec_arith = 1'b1;
               state_in       = rie_pkg::S_PUSH;
            end
         end
         rie_pkg::S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = rie_pkg::S_PUSH;
            end
         end
         rie_pkg::S_PUSH: begin
            cmd.push_result = 1'b1;
            state_in        = rie_pkg::S_IDLE;
         end
         rie_pkg::S_BANG_RD: begin
            cmd.bang_write = 1'b1;
            state_in       = rie_pkg::S_IDLE;
         end
         rie_pkg::S_NL_RD: begin
            cmd.nl_take = 1'b1;
            state_in    = rie_pkg::S_NL_OUT;
         end
         rie_pkg::S_NL_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = rie_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rie_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* dv/rpn_integer_evaluator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_integer_evaluator_test: self-checking bench for the postfix evaluator
// Streams characters of directed and random postfix lines into the block,
// keeps its own stack machine in step with every accepted item, and checks
// each line's value and status in order under changing backpressure.
// ----------------------------------------------------------------------------
module rpn_integer_evaluator_test;

   localparam int STACK_DEPTH       = 256;
   localparam int CYCLE_LIMIT       = 600000;
   localparam int TAIL_CYCLES       = 100;
   localparam int LONG_STALL_CYCLES = 2000;
   localparam int PHASE_ITEMS       = 150;

   localparam logic [rie_pkg::CHAR_W-1:0] BIN_OPS [6] =
      '{rie_pkg::CH_PLUS, rie_pkg::CH_MINUS, rie_pkg::CH_STAR,
        rie_pkg::CH_SLASH, rie_pkg::CH_CARET, rie_pkg::CH_PERCENT};

   typedef struct {
      logic [rie_pkg::CHAR_W-1:0] code;
      bit                         pause;   // marker: hold off until all lines are back
   } char_item_type;

   typedef struct {
      logic signed [rie_pkg::DATA_W-1:0] value;
      logic [rie_pkg::STATUS_W-1:0]      status;
   } line_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [rie_pkg::CHAR_W-1:0]        req_char_code = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [rie_pkg::DATA_W-1:0] rsp_result_value;
   logic [rie_pkg::STATUS_W-1:0]      rsp_status;

   char_item_type   pending_chars[$];
   line_result_type line_results[$];
   logic            req_taken = 1'b0;
   int              fail_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   bit              stall_armed = 1'b0;
   bit              stall_used = 1'b0;
   int              stall_left = 0;
   int              cycle_count = 0;

   // shadow stack machine
   logic [rie_pkg::DATA_W-1:0] calc_stack [STACK_DEPTH];
   int unsigned                calc_depth = 0;
   logic [rie_pkg::DATA_W-1:0] digit_accum = '0;
   bit                         in_digits = 1'b0;
   rie_pkg::status_type        line_err = rie_pkg::ST_OK;

   rpn_integer_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_value(rsp_result_value),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function void flag_line(input rie_pkg::status_type code);
      if (line_err == rie_pkg::ST_OK) line_err = code;
   endfunction

   function void push_calc(input logic [rie_pkg::DATA_W-1:0] v);
      if (calc_depth >= STACK_DEPTH) begin
         flag_line(rie_pkg::ST_OVER);
      end else begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endfunction

   task evaluate_char(input logic [rie_pkg::CHAR_W-1:0] c);
      logic [rie_pkg::DATA_W-1:0] t, s, r;
      longint                     a, b;
      line_result_type            res;
      if (c >= rie_pkg::CH_ZERO && c <= rie_pkg::CH_NINE) begin
         digit_accum = digit_accum * 32'd10 + rie_pkg::DATA_W'(c - rie_pkg::CH_ZERO);
         in_digits = 1'b1;
      end else begin
         // the character that ends a number is still handled below
         if (in_digits) begin
            push_calc(digit_accum);
            in_digits = 1'b0;
            digit_accum = '0;
         end
         case (c)
            rie_pkg::CH_PLUS, rie_pkg::CH_MINUS, rie_pkg::CH_STAR,
            rie_pkg::CH_SLASH, rie_pkg::CH_CARET, rie_pkg::CH_PERCENT: begin
               if (calc_depth < 2) begin
                  flag_line(rie_pkg::ST_UNDER);
               end else begin
                  t = calc_stack[calc_depth-1];
                  s = calc_stack[calc_depth-2];
                  calc_depth -= 2;
                  a = longint'(signed'(s));
                  b = longint'(signed'(t));
                  case (c)
                     rie_pkg::CH_PLUS, rie_pkg::CH_CARET: r = s + t;
                     rie_pkg::CH_MINUS:                   r = s - t;
                     rie_pkg::CH_STAR:                    r = s * t;
                     default: begin
                        // 64-bit math makes min / -1 wrap back to min
                        if (b == 0) begin
                           flag_line(rie_pkg::ST_DIVZ);
                           r = '0;
                        end else if (c == rie_pkg::CH_SLASH) begin
                           r = rie_pkg::DATA_W'(a / b);
                        end else begin
                           r = rie_pkg::DATA_W'(a % b);
                        end
                     end
                  endcase
                  push_calc(r);
               end
            end
            rie_pkg::CH_BANG: begin
               if (calc_depth < 1) flag_line(rie_pkg::ST_UNDER);
               else calc_stack[calc_depth-1] = (calc_stack[calc_depth-1] == '0) ? 1 : 0;
            end
            rie_pkg::CH_NEWLINE: begin
               res.value = '0;
               if (calc_depth == 0) begin
                  flag_line(rie_pkg::ST_UNDER);
               end else begin
                  calc_depth--;
                  res.value = calc_stack[calc_depth];
                  if (calc_depth != 0) flag_line(rie_pkg::ST_LEFT);
               end
               res.status = line_err;
               line_results.push_back(res);
               calc_depth = 0;
               digit_accum = '0;
               in_digits = 1'b0;
               line_err = rie_pkg::ST_OK;
            end
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   // every queued character is one input item
   task add_char(input logic [rie_pkg::CHAR_W-1:0] code, inout int count);
      char_item_type it;
      it.code = code;
      it.pause = 1'b0;
      pending_chars.push_back(it);
      count++;
   endtask

   task add_text(input string s, inout int count);
      for (int i = 0; i < s.len(); i++) add_char(s[i], count);
   endtask

   task add_number(input longint unsigned v, inout int count);
      add_text($sformatf("%0d", v), count);
   endtask

   task add_pause();
      char_item_type it;
      it.code = '0;
      it.pause = 1'b1;
      pending_chars.push_back(it);
   endtask

   task add_signed_operand(input longint unsigned v, input bit negate, inout int count);
      if (negate) add_text("0 ", count);
      add_number(v, count);
      if (negate) add_char(rie_pkg::CH_MINUS, count);
   endtask

   function automatic longint unsigned random_operand();
      longint unsigned v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(9);
         4, 5, 6:    v = $urandom_range(9999);
         7:          v = $urandom();
         8:          v = {$urandom(), $urandom()} % 64'd100000000000;  // wraps
         default: begin
            case ($urandom_range(3))
               0:       v = 64'd2147483647;
               1:       v = 64'd2147483648;
               2:       v = 64'd4294967295;
               default: v = 64'd0;
            endcase
         end
      endcase
      return v;
   endfunction

   // a character the block skips: space, letter, control code or high byte
   function automatic logic [rie_pkg::CHAR_W-1:0] random_filler();
      logic [rie_pkg::CHAR_W-1:0] c;
      case ($urandom_range(5))
         0, 1:    c = " ";
         2:       c = rie_pkg::CHAR_W'("a" + $urandom_range(25));
         3:       c = rie_pkg::CHAR_W'($urandom_range(128, 255));
         4:       c = 8'h09;
         default: c = rie_pkg::CHAR_W'("G" + $urandom_range(19));
      endcase
      return c;
   endfunction

   task add_random_line(inout int count);
      int kind, operands, pushed, depth, tokens;
      bit after_number;
      kind = $urandom_range(99);
      after_number = 1'b0;
      if (kind < 70) begin
         // well-formed expression with random operands and operators
         operands = $urandom_range(1, 6);
         pushed = 0;
         depth = 0;
         while (pushed < operands || depth > 1) begin
            if (pushed < operands && (depth < 2 || $urandom_range(1) == 1)) begin
               if (after_number || $urandom_range(3) == 0) add_char(random_filler(), count);
               add_number(random_operand(), count);
               pushed++;
               depth++;
               after_number = 1'b1;
            end else begin
               if ($urandom_range(4) == 0) add_char(random_filler(), count);
               if ($urandom_range(7) == 0) begin
                  add_char(rie_pkg::CH_BANG, count);
               end else begin
                  add_char(BIN_OPS[$urandom_range(5)], count);
                  depth--;
               end
               after_number = 1'b0;
            end
         end
         if ($urandom_range(5) == 0) add_char(rie_pkg::CH_BANG, count);
         if ($urandom_range(3) == 0) add_char(random_filler(), count);
      end else if (kind < 85) begin
         // division corners: signs, zero divisor, most negative over minus one
         add_signed_operand(($urandom_range(2) == 0) ? 64'd2147483648 : random_operand(),
                            $urandom_range(1), count);
         add_char(" ", count);
         case ($urandom_range(3))
            0:       add_signed_operand(64'd0, 1'b0, count);
            1:       add_signed_operand(64'd1, 1'b1, count);
            2:       add_signed_operand(64'd4294967295, 1'b0, count);
            default: add_signed_operand(random_operand(), $urandom_range(1), count);
         endcase
         add_char(($urandom_range(1) == 0) ? rie_pkg::CH_SLASH : rie_pkg::CH_PERCENT, count);
      end else if (kind < 95) begin
         // broken sequence: underflow, leftovers, stray operators
         tokens = $urandom_range(1, 8);
         repeat (tokens) begin
            case ($urandom_range(3))
               0: begin
                  if (after_number) add_char(" ", count);
                  add_number(random_operand(), count);
                  after_number = 1'b1;
               end
               1: begin add_char(BIN_OPS[$urandom_range(5)], count); after_number = 1'b0; end
               2: begin add_char(rie_pkg::CH_BANG, count); after_number = 1'b0; end
               default: begin add_char(random_filler(), count); after_number = 1'b0; end
            endcase
         end
      end else begin
         // raw byte noise
         repeat ($urandom_range(1, 6)) add_char(rie_pkg::CHAR_W'($urandom_range(255)), count);
      end
      add_char(rie_pkg::CH_NEWLINE, count);
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin : req_driver
      char_item_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_chars.size() != 0 && pending_chars[0].pause) begin
            req_valid <= 1'b0;
            if (line_results.size() == 0) head = pending_chars.pop_front();
         end else if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            head = pending_chars.pop_front();
            req_valid <= 1'b1;
            req_char_code <= head.code;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_armed && !stall_used) begin
         // one long hold-off so the block backs up into its input
         rsp_ready <= 1'b0;
         stall_left <= LONG_STALL_CYCLES;
         stall_used <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : line_monitor
      line_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         calc_depth = 0;
         digit_accum = '0;
         in_digits = 1'b0;
         line_err = rie_pkg::ST_OK;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) evaluate_char(req_char_code);
         if (rsp_valid && rsp_ready) begin
            if (line_results.size() == 0) begin
               $error("unexpected result: result_value %0d status %0d",
                      rsp_result_value, rsp_status);
               fail_count++;
            end else begin
               want = line_results.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d", want.value, rsp_result_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rpn_integer_evaluator: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- test sequence
   initial begin : stimulus
      int work;
      bit paused;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 68;
      work = 0;
      // directed lines
      add_text("\n", work);          // empty line
      add_text("5!\n", work);        // not of nonzero
      add_text("0!\n", work);        // not of zero
      add_text("3 9-\n", work);      // operand order
      add_text("+\n", work);         // underflow
      add_text("8 0/\n", work);      // divide by zero
      add_text("1 2\n", work);       // leftover entries
      add_char("1", work);           // byte extremes end numbers
      add_char(8'h00, work);
      add_char("2", work);
      add_char(8'hFF, work);
      add_text("*\n", work);
      add_pause();

      paused = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 11; recv_idle_pct = 68; end
            1: begin send_idle_pct = 68; recv_idle_pct = 11; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; stall_armed = 1'b1; end
         endcase
         work = 0;
         while (work < PHASE_ITEMS) begin
            add_random_line(work);
            if (phase == 0 && !paused && work >= PHASE_ITEMS / 2) begin
               add_pause();
               paused = 1'b1;
            end
         end
         while (pending_chars.size() != 0) @(negedge clock);
      end

      while (pending_chars.size() != 0 || req_valid || line_results.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && line_results.size() == 0) begin
         $display("rpn_integer_evaluator: match");
      end else begin
         $display("rpn_integer_evaluator: mismatch");
      end
      $finish;
   end

endmodule
